// File: sv/stks_pkg.sv
// ----------------------------------------------------------------------------
// stks_pkg
// Types, codes and sizes shared by the top-k selector cell chain.
// ----------------------------------------------------------------------------
package stks_pkg;

  localparam int ROW_BITS     = 16;
  localparam int VALUE_BITS   = 32;
  localparam int SLOT_ROW_W   = ROW_BITS + 1;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_ADDR_W   = 1;
  localparam int MAX_KEEP_DEF = 16;
  localparam logic [CFG_DATA_W-1:0] KEEP_COUNT_RST = 5'd16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEEP_COUNT    = 1'b0,
    REG_LARGEST_FIRST = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_COLLECT = 1'b0,
    ST_EMIT    = 1'b1
  } sel_state_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         value_finite;
    logic [ROW_BITS-1:0]          row;
    logic [SLOT_ROW_W-1:0]        skip_row;
    logic                         column_end;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_ROW_W-1:0]        slot_row;
    logic signed [VALUE_BITS-1:0] slot_value;
    logic                         slot_filled;
    logic                         slot_last;
  } out_item_t;

  typedef struct packed {
    logic                         valid;
    logic signed [VALUE_BITS-1:0] value;
    logic [ROW_BITS-1:0]          row;
  } entry_t;

  typedef struct packed {
    logic active;
    logic insert;
    logic shift;
    logic largest_first;
  } cell_ctrl_t;

endpackage

// File: sv/stks_cell.sv
// ----------------------------------------------------------------------------
// stks_cell
// One slot of the sorted store: compares the candidate against its entry,
// takes the candidate or its left neighbor on insert, its right on shift.
// ----------------------------------------------------------------------------
module stks_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  stks_pkg::cell_ctrl_t ctrl,
  input  stks_pkg::entry_t    cand,
  input  stks_pkg::entry_t    prev_entry,
  input  logic                prev_better,
  input  stks_pkg::entry_t    next_entry,
  output stks_pkg::entry_t    entry,
  output logic                better
);
  import stks_pkg::*;

  logic                         valid_r, valid_nxt;
  logic signed [VALUE_BITS-1:0] value_r, value_nxt;
  logic [ROW_BITS-1:0]          row_r, row_nxt;

  // empty slot loses to any candidate
  always_comb begin
    if (!valid_r) begin
      better = 1'b1;
    end else if (cand.value != value_r) begin
      better = ctrl.largest_first ? ($signed(cand.value) > $signed(value_r))
                                  : ($signed(cand.value) < $signed(value_r));
    end else begin
      better = cand.row < row_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    row_nxt   = row_r;
    if (!ctrl.active) begin
      // past the keep count: entry dropped on the next offer or shift
      if (ctrl.insert || ctrl.shift) begin
        valid_nxt = 1'b0;
      end
    end else if (ctrl.shift) begin
      valid_nxt = next_entry.valid;
      value_nxt = next_entry.value;
      row_nxt   = next_entry.row;
    end else if (ctrl.insert && better) begin
      if (prev_better) begin
        valid_nxt = prev_entry.valid;
        value_nxt = prev_entry.value;
        row_nxt   = prev_entry.row;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = cand.value;
        row_nxt   = cand.row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    row_r   <= row_nxt;
  end

  assign entry.valid = valid_r;
  assign entry.value = value_r;
  assign entry.row   = row_r;

endmodule

// File: sv/streaming_top_k_selector.sv
// ----------------------------------------------------------------------------
// streaming_top_k_selector
// Keeps the k best entries of a column in a chain of compare-and-shift cells
// and emits them best first at end of column.
// Throughput: one item per cycle while collecting; every candidate is placed
//   by the cell chain in the cycle it is accepted.
// Output: first slot is valid the cycle after the column_end item; the k
//   slots then leave one per cycle while out_ready is high, by shifting
//   the chain toward cell 0.
// Reset: store empty, keep_count 16, largest_first 0.
// ----------------------------------------------------------------------------
module streaming_top_k_selector #(
  parameter int MAX_KEEP = stks_pkg::MAX_KEEP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  stks_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output stks_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [stks_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [stks_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import stks_pkg::*;

  localparam int KW = $clog2(MAX_KEEP + 1);

  logic [CFG_DATA_W-1:0] keep_count_r;
  logic                  largest_first_r;
  logic [KW-1:0]         eff_k;

  sel_state_t            state_r, state_nxt;
  logic [KW-1:0]         slot_cnt_r, slot_cnt_nxt;
  logic                  in_acc, out_acc, slot_last, offer;
  logic [SLOT_ROW_W-1:0] row_p1;

  entry_t                cand;
  entry_t                entries [MAX_KEEP];
  logic [MAX_KEEP-1:0]   better_v;
  logic [MAX_KEEP-1:0]   valid_v;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r    <= KEEP_COUNT_RST;
      largest_first_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_KEEP_COUNT:    keep_count_r    <= cfg_wdata;
        REG_LARGEST_FIRST: largest_first_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (keep_count_r == '0) begin
      eff_k = KW'(1);
    end else if (int'(keep_count_r) > MAX_KEEP) begin
      eff_k = KW'(MAX_KEEP);
    end else begin
      eff_k = KW'(keep_count_r);
    end
  end

  // handshakes and candidate filter
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign slot_last = slot_cnt_r == (eff_k - KW'(1));
  assign row_p1    = {1'b0, in_data.row} + SLOT_ROW_W'(1);
  assign offer     = in_acc && in_data.value_finite &&
                     !((in_data.skip_row != '0) && (row_p1 == in_data.skip_row));

  assign cand.valid = 1'b1;
  assign cand.value = in_data.value;
  assign cand.row   = in_data.row;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    slot_cnt_nxt = slot_cnt_r;
    case (state_r)
      ST_COLLECT: begin
        slot_cnt_nxt = '0;
        if (in_acc && in_data.column_end) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (slot_last) begin
            state_nxt    = ST_COLLECT;
            slot_cnt_nxt = '0;
          end else begin
            slot_cnt_nxt = slot_cnt_r + KW'(1);
          end
        end
      end
      default: begin
        state_nxt    = ST_COLLECT;
        slot_cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      ST_COLLECT: begin
        in_ready  = 1'b1;
        out_valid = 1'b0;
      end
      ST_EMIT: begin
        in_ready  = 1'b0;
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_COLLECT;
      slot_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      slot_cnt_r <= slot_cnt_nxt;
    end
  end

  // cell chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     prev_e, next_e;
    logic       prev_b;

    assign ctrl.active        = KW'(i) < eff_k;
    assign ctrl.insert        = offer;
    assign ctrl.shift         = out_acc;
    assign ctrl.largest_first = largest_first_r;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_b = better_v[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_link
      assign next_e = (KW'(i + 1) < eff_k) ? entries[i+1] : '0;
    end

    stks_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .cand        (cand),
      .prev_entry  (prev_e),
      .prev_better (prev_b),
      .next_entry  (next_e),
      .entry       (entries[i]),
      .better      (better_v[i])
    );

    assign valid_v[i] = entries[i].valid;
  end

  // slot output straight from the head cell
  assign out_data.slot_filled = entries[0].valid;
  assign out_data.slot_row    = entries[0].valid ?
                                ({1'b0, entries[0].row} + SLOT_ROW_W'(1)) : '0;
  assign out_data.slot_value  = entries[0].valid ? entries[0].value : '0;
  assign out_data.slot_last   = slot_last;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output both open");

  a_end_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.column_end) |=> (out_valid && slot_cnt_r == '0))
    else $error("column end did not start emission");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.slot_last) |=> (in_ready && valid_v == '0))
    else $error("store not empty after last slot");

  a_filled_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.slot_filled) |-> (out_data.slot_row != '0))
    else $error("filled slot with empty row");

  a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_v & (valid_v + MAX_KEEP'(1))) == '0))
    else $error("store valid bits not a prefix");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for streaming_top_k_selector. Directed columns cover
// extreme values, ties, skipped entries, empty columns, out-of-range keep
// counts and a keep count cut mid-column. Random columns then run under four
// handshake idling mixes with a long receiver hold-off. Every slot is checked
// against an in-bench sorted-store predictor.
// ----------------------------------------------------------------------------
module tb;
  import stks_pkg::*;

  localparam int KEEP_MAX      = MAX_KEEP_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  in_item_t    entry_q[$];
  out_item_t   slot_q[$];
  int          errors         = 0;
  int unsigned cycles         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs      = 0;
  int          hold_len       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  bit          in_taken       = 1'b0;

  logic [CFG_DATA_W-1:0]        keep_cfg    = KEEP_COUNT_RST;
  bit                           largest_cfg = 1'b0;
  logic signed [VALUE_BITS-1:0] best_value [KEEP_MAX];
  logic [ROW_BITS-1:0]          best_row   [KEEP_MAX];
  int                           best_cnt    = 0;

  streaming_top_k_selector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic int keep_limit();
    if (keep_cfg == 0) return 1;
    if (keep_cfg > KEEP_MAX) return KEEP_MAX;
    return int'(keep_cfg);
  endfunction

  function automatic bit outranks(logic signed [VALUE_BITS-1:0] va, logic [ROW_BITS-1:0] ra,
                                  logic signed [VALUE_BITS-1:0] vb, logic [ROW_BITS-1:0] rb);
    if (va != vb) return largest_cfg ? (va > vb) : (va < vb);
    return ra < rb;
  endfunction

  function automatic void predict_slots(in_item_t it);
    int        k;
    int        pos;
    out_item_t s;
    k = keep_limit();
    if (it.value_finite && !(it.skip_row != 0 && {1'b0, it.row} == it.skip_row - 1)) begin
      if (best_cnt > k) best_cnt = k;
      pos = 0;
      while (pos < best_cnt && !outranks(it.value, it.row, best_value[pos], best_row[pos]))
        pos++;
      if (pos < k) begin
        if (best_cnt < k) best_cnt++;
        for (int i = best_cnt - 1; i > pos; i--) begin
          best_value[i] = best_value[i-1];
          best_row[i]   = best_row[i-1];
        end
        best_value[pos] = it.value;
        best_row[pos]   = it.row;
      end
    end
    if (it.column_end) begin
      if (best_cnt > k) best_cnt = k;
      for (int t = 0; t < k; t++) begin
        s = '0;
        if (t < best_cnt) begin
          s.slot_row    = {1'b0, best_row[t]} + 1'b1;
          s.slot_value  = best_value[t];
          s.slot_filled = 1'b1;
        end
        s.slot_last = (t == k - 1);
        slot_q = {slot_q, s};
      end
      best_cnt = 0;
    end
  endfunction

  function automatic void check_slot(out_item_t got);
    out_item_t want;
    if (slot_q.size() == 0) begin
      $error("unexpected slot: row %0d value %0d", got.slot_row, got.slot_value);
      errors++;
      return;
    end
    want = slot_q.pop_front();
    if (got.slot_filled !== want.slot_filled) begin
      $error("slot_filled expected %0d got %0d", want.slot_filled, got.slot_filled);
      errors++;
    end
    if (got.slot_last !== want.slot_last) begin
      $error("slot_last expected %0d got %0d", want.slot_last, got.slot_last);
      errors++;
    end
    if (got.slot_row !== want.slot_row) begin
      $error("slot_row expected %0d got %0d", want.slot_row, got.slot_row);
      errors++;
    end
    // value is a don't-care on an empty slot
    if (want.slot_filled && got.slot_value !== want.slot_value) begin
      $error("slot_value expected %0d got %0d", want.slot_value, got.slot_value);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) predict_slots(in_data);
      if (out_valid && out_ready) check_slot(out_data);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (entry_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= entry_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void push_entry(logic signed [VALUE_BITS-1:0] v, bit fin,
                                     logic [ROW_BITS-1:0] r, logic [SLOT_ROW_W-1:0] self,
                                     bit last);
    in_item_t it;
    it.value        = v;
    it.value_finite = fin;
    it.row          = r;
    it.skip_row     = self;
    it.column_end   = last;
    entry_q = {entry_q, it};
  endfunction

  function automatic void push_column(int len);
    logic [ROW_BITS-1:0]          rows[$];
    logic [SLOT_ROW_W-1:0]        self;
    logic signed [VALUE_BITS-1:0] v;
    int                           sel;
    int                           near;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(9);
      if (sel < 5) rows = {rows, ROW_BITS'($urandom_range(15))};
      else if (sel < 9) rows = {rows, ROW_BITS'($urandom_range(65535))};
      else rows = {rows, 16'hFFFF};
    end
    sel = $urandom_range(9);
    if (sel < 3) self = '0;
    else if (sel < 5) self = SLOT_ROW_W'($urandom_range(65536));
    else self = {1'b0, rows[$urandom_range(len - 1)]} + 1'b1;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        near = int'($urandom_range(6)) - 3;
        v = near * 65536;
      end else if (sel < 55) begin
        v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        v = $urandom;
      end
      push_entry(v, $urandom_range(99) < 92, rows[i], self, i == len - 1);
    end
  endfunction

  task automatic settle();
    while (entry_q.size() != 0 || in_valid || slot_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == REG_KEEP_COUNT) keep_cfg = val;
    else largest_cfg = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                    n;
    int                    len;
    int                    sel;
    logic [CFG_DATA_W-1:0] keeps [4];
    int                    sidle [4];
    int                    rstall[4];
    keeps  = '{5'd16, 5'd5, 5'd1, 5'd31};
    sidle  = '{0, 46, 0, 17};
    rstall = '{0, 0, 46, 17};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // extremes, non-finite, self row, ties
    push_entry(32'sh7FFF_FFFF, 1, 16'd0, 17'd0, 0);
    push_entry(32'sh8000_0000, 1, 16'hFFFF, 17'd0, 0);
    push_entry(32'sd5 <<< 16, 0, 16'd10, 17'd0, 0);
    push_entry(32'sd5 <<< 16, 1, 16'd20, 17'd21, 0);
    push_entry(32'sd7 <<< 16, 1, 16'd3, 17'd21, 0);
    push_entry(32'sd7 <<< 16, 1, 16'd2, 17'd21, 0);
    push_entry(32'sd7 <<< 16, 1, 16'd2, 17'd21, 0);
    push_entry(-32'sd1, 1, 16'd4, 17'h10000, 1);
    // empty columns
    push_entry(32'sd0, 0, 16'd0, 17'd0, 1);
    push_entry(32'sd3, 1, 16'hFFFF, 17'h10000, 1);
    settle();

    write_cfg(REG_KEEP_COUNT, 5'd1);
    write_cfg(REG_LARGEST_FIRST, 5'd1);
    push_entry(-32'sd5, 1, 16'd1, 17'd0, 0);
    push_entry(32'sd9, 1, 16'd7, 17'd0, 0);
    push_entry(32'sd9, 1, 16'd6, 17'd0, 0);
    push_entry(32'sd9, 1, 16'd6, 17'd0, 1);
    settle();

    write_cfg(REG_KEEP_COUNT, 5'd0);
    write_cfg(REG_LARGEST_FIRST, 5'd0);
    push_entry(32'sd2, 1, 16'd0, 17'd0, 0);
    push_entry(32'sd1, 1, 16'd1, 17'd0, 1);
    settle();

    write_cfg(REG_KEEP_COUNT, 5'd31);
    push_entry(32'sd1, 1, 16'd1, 17'd0, 1);
    settle();

    // keep count cut mid-column
    write_cfg(REG_KEEP_COUNT, 5'd16);
    push_entry(32'sd40, 1, 16'd0, 17'd0, 0);
    push_entry(32'sd10, 1, 16'd1, 17'd0, 0);
    push_entry(32'sd30, 1, 16'd2, 17'd0, 0);
    push_entry(32'sd20, 1, 16'd3, 17'd0, 0);
    push_entry(32'sd50, 1, 16'd4, 17'd0, 0);
    settle();
    write_cfg(REG_KEEP_COUNT, 5'd2);
    push_entry(32'sd25, 1, 16'd5, 17'd0, 0);
    push_entry(32'sd15, 1, 16'd6, 17'd0, 1);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_cfg(REG_KEEP_COUNT, keeps[ph]);
      write_cfg(REG_LARGEST_FIRST, CFG_DATA_W'(ph % 2));
      @(posedge clk);
      send_idle_pct  = sidle[ph];
      recv_stall_pct = rstall[ph];
      if (ph == 0) begin
        hold_len = 400;
        hold_reqs++;
      end
      n = 0;
      while (n < 105) begin
        sel = $urandom_range(99);
        if (ph == 0 && n < 40) len = $urandom_range(1, 3);
        else if (sel < 80) len = $urandom_range(1, 12);
        else if (sel < 95) len = $urandom_range(13, 24);
        else len = $urandom_range(30, 40);
        push_column(len);
        n += len;
      end
    end

    settle();
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
sv/stks_pkg.sv
sv/stks_cell.sv
sv/streaming_top_k_selector.sv
tb/sv/tb.sv
